[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL.
// Depends on nothing; assertions vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

[rtl/core/bezout_pkg.sv]
// Shared constants and types for the Bezout coefficient block.
// No dependencies.
`timescale 1ns / 1ps
package bezout_pkg;
  localparam int unsigned DefOperandWidth = 32;
  localparam int unsigned CoeffWidth = 64;
  localparam int unsigned ResultWidth = 32;

  typedef enum logic [1:0] {
    CLS_B_ZERO,
    CLS_GENERAL
  } item_class_e;
endpackage

[rtl/core/bezout_front.sv]
// Front end: accepts operand pairs, classifies them, and queues them.
// Depends on bezout_pkg.
`timescale 1ns / 1ps
module bezout_front import bezout_pkg::*; #(
  parameter int unsigned OperandWidth = DefOperandWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [OperandWidth-1:0] operand_a_i,
  input  logic [OperandWidth-1:0] operand_b_i,
  output logic                    q_valid_o,
  input  logic                    q_take_i,
  output item_class_e             q_class_o,
  output logic [OperandWidth-1:0] q_a_o,
  output logic [OperandWidth-1:0] q_b_o
);
  // two-entry queue
  logic [OperandWidth-1:0] a_q [2];
  logic [OperandWidth-1:0] b_q [2];
  item_class_e             cls_q [2];
  logic                    wp_q, rp_q;
  logic [1:0]              cnt_q;
  logic                    wr, rd;

  assign full      = cnt_q == 2'd2;
  assign wr        = push && !full;
  assign rd        = q_take_i && q_valid_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_class_o = cls_q[rp_q];
  assign q_a_o     = a_q[rp_q];
  assign q_b_o     = b_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      a_q[wp_q]   <= operand_a_i;
      b_q[wp_q]   <= operand_b_i;
      cls_q[wp_q] <= (operand_b_i == '0) ? CLS_B_ZERO : CLS_GENERAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

[rtl/core/bezout_back.sv]
// Back end: runs Euclid rounds with a restoring divider and serial multiply.
// Depends on bezout_pkg.
`timescale 1ns / 1ps
module bezout_back import bezout_pkg::*; #(
  parameter int unsigned OperandWidth = DefOperandWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  output logic                    q_take_o,
  input  item_class_e             q_class_i,
  input  logic [OperandWidth-1:0] q_a_i,
  input  logic [OperandWidth-1:0] q_b_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [ResultWidth-1:0]  coeff_a_o,
  output logic [ResultWidth-1:0]  coeff_b_o
);
  localparam int unsigned CntW = $clog2(OperandWidth + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_CHECK, ST_MUL, ST_UPD, ST_DONE
  } state_e;

  state_e                  state_q;
  logic [OperandWidth-1:0] rc_q, quo_q, rem_q;
  logic [CntW-1:0]         cnt_q;
  logic [CoeffWidth-1:0]   xap_q, xac_q, xbp_q, xbc_q, pa_q, pb_q;
  logic [CoeffWidth-1:0]   ma_q, mb_q;
  logic [ResultWidth-1:0]  oa_q, ob_q;
  logic                    full_q;
  logic                    res_load;
  logic [OperandWidth:0]   trial;
  logic [OperandWidth-1:0] rem_sh;

  assign q_take_o  = (state_q == ST_IDLE) && q_valid_i;
  assign empty     = !full_q;
  assign coeff_a_o = oa_q;
  assign coeff_b_o = ob_q;
  assign res_load  = (state_q == ST_DONE) && (!full_q || pop);
  assign rem_sh    = {rem_q[OperandWidth-2:0], quo_q[OperandWidth-1]};
  assign trial     = {rem_q, quo_q[OperandWidth-1]} - {1'b0, rc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      full_q  <= 1'b0;
    end else begin
      if (res_load) full_q <= 1'b1;
      else if (pop && full_q) full_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (q_valid_i) begin
          rc_q  <= q_b_i;
          xap_q <= CoeffWidth'(1);
          xac_q <= '0;
          xbp_q <= '0;
          xbc_q <= CoeffWidth'(1);
          if (q_class_i == CLS_B_ZERO) state_q <= ST_DONE;
          else begin
            quo_q   <= q_a_i;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          // one restoring step per cycle, quotient shifts in from the right
          if (!trial[OperandWidth]) begin
            rem_q <= trial[OperandWidth-1:0];
            quo_q <= {quo_q[OperandWidth-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[OperandWidth-2:0], 1'b0};
          end
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(OperandWidth - 1)) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (rem_q == '0) state_q <= ST_DONE;
          else begin
            ma_q    <= xac_q;
            mb_q    <= xbc_q;
            pa_q    <= '0;
            pb_q    <= '0;
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          // shift-add product of quotient and current coefficients
          if (quo_q[0]) begin
            pa_q <= pa_q + ma_q;
            pb_q <= pb_q + mb_q;
          end
          ma_q  <= {ma_q[CoeffWidth-2:0], 1'b0};
          mb_q  <= {mb_q[CoeffWidth-2:0], 1'b0};
          quo_q <= {1'b0, quo_q[OperandWidth-1:1]};
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(OperandWidth - 1)) state_q <= ST_UPD;
        end
        ST_UPD: begin
          xap_q   <= xac_q;
          xac_q   <= xap_q - pa_q;
          xbp_q   <= xbc_q;
          xbc_q   <= xbp_q - pb_q;
          rc_q    <= rem_q;
          quo_q   <= rc_q;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DONE: if (res_load) begin
          oa_q    <= xac_q[ResultWidth-1:0];
          ob_q    <= xbc_q[ResultWidth-1:0];
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/bezout_coefficients_euclid_top.sv]
// Top level of the Bezout coefficient block.
// Depends on bezout_pkg, bezout_front, bezout_back, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage: push operand_a_i/operand_b_i while full is low; read coeff_a_o and
// coeff_b_o while empty is low and pulse pop to take them.
// A two-entry queue holds accepted operands so the caller can push while
// the back end works. Each Euclid round runs a restoring division, a
// check of the remainder, a shift-add multiply and a coefficient update.
// The last round stops after its division and check. A zero second
// operand skips the rounds: the back end goes straight to its done state
// and loads the result register once that register is free.
// One result register holds the output; when pop stays low the back end
// waits in its done state and the queue fills, then full rises.
// Reset empties the queue and the result register.
module bezout_coefficients_euclid_top import bezout_pkg::*; #(
  parameter int unsigned OperandWidth = DefOperandWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [OperandWidth-1:0] operand_a_i,
  input  logic [OperandWidth-1:0] operand_b_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [ResultWidth-1:0]  coeff_a_o,
  output logic [ResultWidth-1:0]  coeff_b_o
);
  logic                    q_valid, q_take;
  item_class_e             q_class;
  logic [OperandWidth-1:0] q_a, q_b;

  bezout_front #(.OperandWidth(OperandWidth)) u_front (
    .clk_i, .rst_ni, .push, .full, .operand_a_i, .operand_b_i,
    .q_valid_o(q_valid), .q_take_i(q_take), .q_class_o(q_class),
    .q_a_o(q_a), .q_b_o(q_b)
  );

  bezout_back #(.OperandWidth(OperandWidth)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_take_o(q_take),
    .q_class_i(q_class), .q_a_i(q_a), .q_b_i(q_b),
    .empty, .pop, .coeff_a_o, .coeff_b_o
  );

  `ASSERT_NEVER(a_take_needs_valid, q_take && !q_valid, "take from empty queue")
  `ASSERT_IMPL(a_hold_out, (!empty && !pop) |=> $stable(coeff_a_o) && !empty, "result moved")
endmodule
